// ===== src/arf_pkg.sv =====
// Shared types and constants for the receive audio ring FIFO.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none
package arf_pkg;

	localparam int RING_DEPTH      = 1024;
	localparam int MAX_BLOCK_PAIRS = 64;
	localparam int PTR_W           = $clog2(RING_DEPTH);
	localparam int SAMPLE_W        = 24;
	localparam int WORD_W          = 32;
	localparam int PAIR_W          = 7;
	// Width that holds both a stored count and twice a pair count.
	localparam int CMP_W           = (PTR_W > PAIR_W + 1) ? PTR_W : PAIR_W + 1;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_POP   = 1'b1;

	typedef struct packed {
		logic                mode;
		logic [SAMPLE_W-1:0] sample_bytes;
		logic                packet_end;
		logic [PAIR_W-1:0]   pair_count;
	} req_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] left_sample;
		logic signed [WORD_W-1:0] right_sample;
		logic                     pop_ok;
		logic                     last_pair;
		logic [WORD_W-1:0]        overrun_total;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic wr;       // store or drop one sample
		logic fail;     // load the failure beat
		logic emit;     // load one pair beat and advance the read pointer
		logic last;     // the pair beat being loaded ends the pop
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic enough;   // the pending pop request can be served in full
		logic out_free; // the output register can take a beat this cycle
	} sts_t;

endpackage
`default_nettype wire

// ===== src/arf_ctrl.sv =====
// Controller of the receive audio ring FIFO: accepts requests and sequences pops.
// Depends on arf_pkg for the command and status structs.
`default_nettype none
module arf_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       req_valid,
	output logic                            req_ready,
	input  wire logic                       mode,
	input  wire logic [arf_pkg::PAIR_W-1:0] pair_count,
	input  wire arf_pkg::sts_t              sts,
	output arf_pkg::cmd_t                   cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_STREAM
	} state_t;

	state_t                     state_q;
	logic [arf_pkg::PAIR_W-1:0] left_q;
	logic                       accept;

	// A write needs no output slot; a pop waits until the output register can take a beat.
	assign req_ready = (state_q == ST_IDLE) && ((mode == arf_pkg::MODE_WRITE) || sts.out_free);
	assign accept    = req_valid && req_ready;

	always_comb begin
		cmd.wr   = accept && (mode == arf_pkg::MODE_WRITE);
		cmd.fail = accept && (mode == arf_pkg::MODE_POP) && !sts.enough;
		cmd.emit = (state_q == ST_STREAM) && sts.out_free;
		cmd.last = (left_q == arf_pkg::PAIR_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			left_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (mode == arf_pkg::MODE_POP) && sts.enough) begin
						state_q <= ST_STREAM;
						left_q  <= pair_count;
					end
				end
				ST_STREAM: begin
					if (cmd.emit) begin
						left_q <= left_q - arf_pkg::PAIR_W'(1);
						if (cmd.last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== src/arf_dp.sv =====
// Datapath of the receive audio ring FIFO: sample ring, pointers, overrun
// tracking and the output register. Depends on arf_pkg.
`default_nettype none
module arf_dp (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire arf_pkg::req_t req,
	input  wire arf_pkg::cmd_t cmd,
	output arf_pkg::sts_t      sts,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output arf_pkg::rsp_t      rsp
);

	localparam int PW = arf_pkg::PTR_W;
	localparam int CW = arf_pkg::CMP_W;

	logic [arf_pkg::SAMPLE_W-1:0] ring_q [arf_pkg::RING_DEPTH];

	logic [PW-1:0]                wp_q;
	logic [PW-1:0]                rp_q;
	logic [arf_pkg::WORD_W-1:0]   overrun_q;
	logic                         drop_q;
	logic                         out_valid_q;
	arf_pkg::rsp_t                out_q;
	logic [arf_pkg::SAMPLE_W-1:0] left_s1;
	logic [arf_pkg::SAMPLE_W-1:0] right_s1;

	logic [PW-1:0] wp_nxt;
	logic [PW-1:0] rp_inc1;
	logic [PW-1:0] rp_inc2;
	logic [PW-1:0] rd_a;
	logic [PW-1:0] rd_b;
	logic [PW:0]   count;
	logic          full;
	logic          pairs_ok;

	function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
		return (p == PW'(arf_pkg::RING_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign wp_nxt  = next_slot(wp_q);
	assign rp_inc1 = next_slot(rp_q);
	assign rp_inc2 = next_slot(rp_inc1);
	assign full    = (wp_nxt == rp_q);

	always_comb begin
		if (wp_q >= rp_q) begin
			count = {1'b0, wp_q} - {1'b0, rp_q};
		end else begin
			count = {1'b0, wp_q} + (PW+1)'(arf_pkg::RING_DEPTH) - {1'b0, rp_q};
		end
	end

	assign pairs_ok = (req.pair_count != '0)
		&& (req.pair_count <= arf_pkg::PAIR_W'(arf_pkg::MAX_BLOCK_PAIRS))
		&& (CW'(count) >= CW'({req.pair_count, 1'b0}));

	assign sts.enough   = pairs_ok;
	assign sts.out_free = !out_valid_q || rsp_ready;

	// The read ports always look at the pair the read pointer will hold next cycle,
	// so the registered read data is ready the moment the pointer moves.
	assign rd_a = cmd.emit ? rp_inc2 : rp_q;
	assign rd_b = next_slot(rd_a);

	always_ff @(posedge clk) begin
		if (cmd.wr && !drop_q && !full) begin
			ring_q[wp_q] <= req.sample_bytes;
		end
		left_s1  <= ring_q[rd_a];
		right_s1 <= ring_q[rd_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			rp_q      <= '0;
			overrun_q <= '0;
			drop_q    <= 1'b0;
		end else begin
			if (cmd.wr) begin
				if (!drop_q) begin
					if (full) begin
						overrun_q <= overrun_q + arf_pkg::WORD_W'(1);
						drop_q    <= !req.packet_end;
					end else begin
						wp_q <= wp_nxt;
					end
				end
				if (req.packet_end) begin
					drop_q <= 1'b0;
				end
			end
			if (cmd.emit) begin
				rp_q <= rp_inc2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.fail) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.left_sample   <= {left_s1, 8'h00};
			out_q.right_sample  <= {right_s1, 8'h00};
			out_q.pop_ok        <= 1'b1;
			out_q.last_pair     <= cmd.last;
			out_q.overrun_total <= overrun_q;
		end else if (cmd.fail) begin
			out_q.left_sample   <= '0;
			out_q.right_sample  <= '0;
			out_q.pop_ok        <= 1'b0;
			out_q.last_pair     <= 1'b1;
			out_q.overrun_total <= overrun_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule
`default_nettype wire

// ===== src/audio_rx_ring_fifo_24bit.sv =====
// Top level of the receive audio ring FIFO.
// Instantiates arf_ctrl and arf_dp; depends on arf_pkg.
//
// Receive-side audio FIFO for packed 24-bit samples held in a ring of
// RING_DEPTH slots with one slot always kept empty. A write beat (mode 0)
// stores one sample and is taken every cycle while no pop is in progress; it
// produces no response, and a full ring counts one overrun per packet and
// drops the rest of that packet through its packet_end beat. A pop beat
// (mode 1) either answers with one failure beat or streams pair_count
// left/right Q31 pairs, one pair per cycle while the response side takes
// them. The request is accepted first; the pairs are then loaded into the
// output register one after another through the two read ports of the sample
// memory, and no new request is taken until the last pair is loaded. A pop
// is accepted only when the output register is empty or draining.
`default_nettype none
module audio_rx_ring_fifo_24bit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire arf_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output arf_pkg::rsp_t      rsp
);

	arf_pkg::cmd_t cmd;
	arf_pkg::sts_t sts;

	arf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.mode       (req.mode),
		.pair_count (req.pair_count),
		.sts        (sts),
		.cmd        (cmd)
	);

	arf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire
